[hw/rtl/pfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the Playfair digraph decipher unit.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned Side      = 5;
  localparam int unsigned CellCount = Side * Side;
  localparam int unsigned LetterW   = 5;
  localparam int unsigned RowW      = $clog2(Side);
  localparam int unsigned KeyWordW  = 60;
  localparam int unsigned WordCells = KeyWordW / LetterW;
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [RowW-1:0]    coord_t;
  typedef letter_t [CellCount-1:0] cells_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LAST = 2'd2
  } cfg_idx_e;

  // Per-cell compare outcome for both letters of a digraph
  typedef struct packed {
    logic first;
    logic second;
  } lane_match_t;

  // Merged match vectors carried between stages
  typedef struct packed {
    logic [CellCount-1:0] first;
    logic [CellCount-1:0] second;
  } match_vec_t;

endpackage

[hw/rtl/pfd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_if
// Channel interfaces: ciphertext input, plaintext output, configuration write.
// ----------------------------------------------------------------------------
interface pfd_in_if import pfd_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t cipher_first;
  letter_t cipher_second;
  logic    last_pair;

  modport source (output valid, cipher_first, cipher_second, last_pair, input ready);
  modport sink   (input valid, cipher_first, cipher_second, last_pair, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t plain_first;
  letter_t plain_second;
  logic    letter_not_found;
  logic    last_out;

  modport source (output valid, plain_first, plain_second, letter_not_found, last_out,
                  input ready);
  modport sink   (input valid, plain_first, plain_second, letter_not_found, last_out,
                  output ready);
endinterface

interface pfd_cfg_if import pfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [KeyWordW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/playfair_digraph_decipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_decipher_unit
// Playfair digraph decipher: 25 compare lanes locate both letters, a merge
// stage applies the row, column and rectangle rules.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cfg_i     in   valid/ready    index, data (key square words)
//  cipher_i  in   valid/ready    cipher_first, cipher_second, last_pair
//  plain_o   out  valid/ready    plain_first, plain_second, letter_not_found,
//                                last_out
//
//  One digraph per cycle while plain_o is ready; each result passes the lane
//  compare register, then the merge stage into the output register, where
//  plain_o.valid is raised.
//  Reset clears the key square to zero and empties both stages.
//  A stall on plain_o holds the output register; the lane stage keeps
//  accepting until it too is full. cfg_i is always ready.
// ----------------------------------------------------------------------------
module playfair_digraph_decipher_unit import pfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfd_cfg_if.sink   cfg_i,
  pfd_in_if.sink    cipher_i,
  pfd_out_if.source plain_o
);

  logic [KeyWordW-1:0] key_low_q, key_high_q;
  letter_t             key_last_q;
  cells_t              cells;

  match_vec_t match_d, match_q;
  logic       last1_q;
  logic       s1_valid_q;
  logic       s1_advance;

  letter_t plain_first_d, plain_second_d;
  logic    not_found_d;
  letter_t plain_first_q, plain_second_q;
  logic    not_found_q, last_out_q;
  logic    out_valid_q;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_last_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KEY_LOW:  key_low_q  <= cfg_i.data;
        CFG_KEY_HIGH: key_high_q <= cfg_i.data;
        CFG_KEY_LAST: key_last_q <= cfg_i.data[LetterW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < WordCells; i++) begin : g_cells
    assign cells[i]           = key_low_q[i*LetterW +: LetterW];
    assign cells[WordCells+i] = key_high_q[i*LetterW +: LetterW];
  end
  assign cells[CellCount-1] = key_last_q;

  // Compare lanes
  for (genvar i = 0; i < CellCount; i++) begin : g_lane
    lane_match_t lm;
    pfd_match_lane u_lane (
      .cell_i   (cells[i]),
      .first_i  (cipher_i.cipher_first),
      .second_i (cipher_i.cipher_second),
      .match_o  (lm)
    );
    assign match_d.first[i]  = lm.first;
    assign match_d.second[i] = lm.second;
  end

  // Pipeline control: advance stage 1 when the output slot is free or draining
  assign s1_advance     = !out_valid_q || plain_o.ready;
  assign cipher_i.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cipher_i.ready) s1_valid_q <= cipher_i.valid;
      if (s1_advance)     out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cipher_i.valid && cipher_i.ready) begin
      match_q <= match_d;
      last1_q <= cipher_i.last_pair;
    end
    if (s1_valid_q && s1_advance) begin
      plain_first_q  <= plain_first_d;
      plain_second_q <= plain_second_d;
      not_found_q    <= not_found_d;
      last_out_q     <= last1_q;
    end
  end

  pfd_merge u_merge (
    .match_i        (match_q),
    .cells_i        (cells),
    .plain_first_o  (plain_first_d),
    .plain_second_o (plain_second_d),
    .not_found_o    (not_found_d)
  );

  assign plain_o.valid            = out_valid_q;
  assign plain_o.plain_first      = plain_first_q;
  assign plain_o.plain_second     = plain_second_q;
  assign plain_o.letter_not_found = not_found_q;
  assign plain_o.last_out         = last_out_q;

endmodule

[hw/rtl/pfd_match_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_match_lane
// Compares one key square cell against both ciphertext letters.
// ----------------------------------------------------------------------------
module pfd_match_lane import pfd_pkg::*; (
  input  letter_t     cell_i,
  input  letter_t     first_i,
  input  letter_t     second_i,
  output lane_match_t match_o
);

  assign match_o.first  = (cell_i == first_i);
  assign match_o.second = (cell_i == second_i);

endmodule

[hw/rtl/pfd_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_merge
// Combines lane matches into positions, applies the three Playfair rules
// and selects the plaintext letters from the key square.
// ----------------------------------------------------------------------------
module pfd_merge import pfd_pkg::*; (
  input  match_vec_t match_i,
  input  cells_t     cells_i,
  output letter_t    plain_first_o,
  output letter_t    plain_second_o,
  output logic       not_found_o
);

  logic   found_a, found_b;
  coord_t row_a, col_a, row_b, col_b;
  coord_t trow_a, tcol_a, trow_b, tcol_b;
  letter_t sel_a, sel_b;

  function automatic coord_t step_back(coord_t x);
    coord_t r;
    if (x == '0) r = coord_t'(Side - 1);
    else         r = x - coord_t'(1);
    return r;
  endfunction

  // Lowest-numbered matching cell wins: scan downwards, last hit sticks
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    row_a   = '0;
    col_a   = '0;
    row_b   = '0;
    col_b   = '0;
    for (int r = Side - 1; r >= 0; r--) begin
      for (int c = Side - 1; c >= 0; c--) begin
        if (match_i.first[r*Side+c]) begin
          found_a = 1'b1;
          row_a   = coord_t'(r);
          col_a   = coord_t'(c);
        end
        if (match_i.second[r*Side+c]) begin
          found_b = 1'b1;
          row_b   = coord_t'(r);
          col_b   = coord_t'(c);
        end
      end
    end
  end

  always_comb begin
    if (row_a == row_b) begin
      trow_a = row_a;
      tcol_a = step_back(col_a);
      trow_b = row_b;
      tcol_b = step_back(col_b);
    end else if (col_a == col_b) begin
      trow_a = step_back(row_a);
      tcol_a = col_a;
      trow_b = step_back(row_b);
      tcol_b = col_b;
    end else begin
      trow_a = row_a;
      tcol_a = col_b;
      trow_b = row_b;
      tcol_b = col_a;
    end
  end

  // One-hot AND-OR select over the square
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (trow_a == coord_t'(r) && tcol_a == coord_t'(c)) sel_a = sel_a | cells_i[r*Side+c];
        if (trow_b == coord_t'(r) && tcol_b == coord_t'(c)) sel_b = sel_b | cells_i[r*Side+c];
      end
    end
  end

  assign not_found_o    = !(found_a && found_b);
  assign plain_first_o  = not_found_o ? '0 : sel_a;
  assign plain_second_o = not_found_o ? '0 : sel_b;

endmodule
